### sv/calibration_point_sorted_insert_assert.svh
// Assertion macros for the checker file of the calibration point table.
`ifndef CALIBRATION_POINT_SORTED_INSERT_ASSERT_SVH
`define CALIBRATION_POINT_SORTED_INSERT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("calibration point table check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("calibration point table check failed");

`endif

### sv/cpsi_pkg.sv
package cpsi_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_TILT    = 2'd0;
    localparam logic [1:0] FUNC_GRAVITY = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] tilt;
        logic [15:0] gravity;
        logic [3:0]  index;
    } t_in_item;

    typedef struct packed {
        logic        point_added;
        logic [3:0]  position;
        logic [4:0]  point_count;
        logic        entry_valid;
        logic [15:0] entry_tilt;
        logic [15:0] entry_gravity;
    } t_out_item;

    typedef struct packed {
        logic [15:0] tilt;
        logic [15:0] gravity;
    } t_point;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic upd_tilt;
        logic set_pending;
        logic clr_pending;
        logic ins_start;
        logic rd_index;
        logic shift;
        logic wr_new;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       latest_valid;
        logic       pending_valid;
        logic       full;
        logic       count_zero;
        logic       read_ok;
        logic       ptr_one;
        logic       shift_needed;
    } t_dp_status;

endpackage

### sv/cpsi_in_if.sv
interface cpsi_in_if;
    import cpsi_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/cpsi_out_if.sv
interface cpsi_out_if;
    import cpsi_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/cpsi_datapath.sv
module cpsi_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cpsi_pkg::t_in_item    i_item,
    input  cpsi_pkg::t_ctl_cmd    i_cmd,
    output cpsi_pkg::t_dp_status  o_status,
    output cpsi_pkg::t_out_item   o_result
);
    import cpsi_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_point        r_mem [MAX_POINTS];
    t_point        r_rd_data;
    t_in_item      r_item;
    t_point        r_new;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [15:0]   r_latest_tilt;
    logic          r_latest_valid;
    logic          n_latest_valid;
    logic [15:0]   r_pending;
    logic          r_pending_valid;
    logic          n_pending_valid;
    logic          r_added;
    logic [3:0]    r_pos;
    logic          r_ev;
    t_out_item     r_out;

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ins_start) begin
            n_ptr = AW'(r_count);
        end else if (i_cmd.shift) begin
            n_ptr = r_ptr - AW'(1);
        end
    end

    // Insertion reads the entry just below the next pointer.
    assign rd_addr = i_cmd.rd_index ? AW'(r_item.index) : (n_ptr - AW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start || i_cmd.shift || i_cmd.rd_index) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_mem[r_ptr] <= r_rd_data;
        end else if (i_cmd.wr_new) begin
            r_mem[r_ptr] <= r_new;
        end
    end

    always_comb begin
        n_count         = r_count;
        n_latest_valid  = r_latest_valid;
        n_pending_valid = r_pending_valid;
        if (i_cmd.wr_new) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.upd_tilt) begin
            n_latest_valid = 1'b1;
        end
        if (i_cmd.set_pending) begin
            n_pending_valid = 1'b1;
        end else if (i_cmd.clr_pending) begin
            n_pending_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_latest_valid  <= 1'b0;
            r_pending_valid <= 1'b0;
        end else begin
            r_count         <= n_count;
            r_latest_valid  <= n_latest_valid;
            r_pending_valid <= n_pending_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.capture) begin
            r_item  <= i_item;
            r_added <= 1'b0;
            r_pos   <= '0;
            r_ev    <= 1'b0;
        end
        if (i_cmd.upd_tilt) begin
            r_latest_tilt <= r_item.tilt;
        end
        if (i_cmd.set_pending) begin
            r_pending <= r_item.gravity;
        end
        if (i_cmd.ins_start) begin
            // A tilt item pairs its own tilt with the pending gravity.
            if (r_item.func == FUNC_TILT) begin
                r_new.tilt    <= r_item.tilt;
                r_new.gravity <= r_pending;
            end else begin
                r_new.tilt    <= r_latest_tilt;
                r_new.gravity <= r_item.gravity;
            end
        end
        if (i_cmd.rd_index) begin
            r_ev <= 1'b1;
        end
        if (i_cmd.wr_new) begin
            r_added <= 1'b1;
            r_pos   <= 4'(r_ptr);
        end
        if (i_cmd.out_load) begin
            r_out.point_added   <= r_added;
            r_out.position      <= r_pos;
            r_out.point_count   <= 5'(r_count);
            r_out.entry_valid   <= r_ev;
            r_out.entry_tilt    <= r_ev ? r_rd_data.tilt : 16'd0;
            r_out.entry_gravity <= r_ev ? r_rd_data.gravity : 16'd0;
        end
    end

    assign o_status.func          = r_item.func;
    assign o_status.latest_valid  = r_latest_valid;
    assign o_status.pending_valid = r_pending_valid;
    assign o_status.full          = (r_count == CW'(MAX_POINTS));
    assign o_status.count_zero    = (r_count == '0);
    assign o_status.read_ok       = ((CW + 4)'(r_item.index) < (CW + 4)'(r_count));
    assign o_status.ptr_one       = (r_ptr == AW'(1));
    assign o_status.shift_needed  = (r_rd_data.tilt >= r_new.tilt);
    assign o_result               = r_out;

endmodule

### sv/cpsi_controller.sv
module cpsi_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  cpsi_pkg::t_dp_status  i_status,
    output cpsi_pkg::t_ctl_cmd    o_cmd
);
    import cpsi_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_WRNEW  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FINISH;
                unique case (i_status.func)
                    FUNC_TILT: begin
                        o_cmd.upd_tilt = 1'b1;
                        if (i_status.pending_valid && !i_status.full) begin
                            o_cmd.ins_start   = 1'b1;
                            o_cmd.clr_pending = 1'b1;
                            n_state = i_status.count_zero ? S_WRNEW : S_CMP;
                        end
                    end
                    FUNC_GRAVITY: begin
                        if (i_status.latest_valid && !i_status.full) begin
                            o_cmd.ins_start = 1'b1;
                            n_state = i_status.count_zero ? S_WRNEW : S_CMP;
                        end else begin
                            o_cmd.set_pending = 1'b1;
                        end
                    end
                    FUNC_READ: begin
                        if (i_status.read_ok) begin
                            o_cmd.rd_index = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CMP: begin
                if (i_status.shift_needed) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.ptr_one) begin
                        n_state = S_WRNEW;
                    end
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_WRNEW: begin
                o_cmd.wr_new = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/calibration_point_sorted_insert.sv
// Calibration point table: tilt readings and gravity readings arrive as beats on the input
// channel and are paired into points that are kept sorted by ascending tilt, up to
// MAX_POINTS of them; every input beat produces exactly one result beat. The block works on
// one item at a time. A tilt item, a gravity item that adds no point, a read and an unused
// code each pass from the accepting edge through the decide and finish states until the
// result is offered, and the input is ready again as the result is offered. An insertion
// walks the table downward from the top entry through the single read and write port of
// the point memory, one entry per cycle, shifting up each stored entry whose tilt is not
// less than the new tilt, then writes the new point. The result sits in an output register,
// and the next item is accepted while that result is still waiting to be taken; that next
// item then waits in its last step until the register is free.

module calibration_point_sorted_insert #(
    parameter int MAX_POINTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpsi_in_if.sink           i_in,
    cpsi_out_if.source        o_out
);
    import cpsi_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_ctl_cmd   cmd;
    t_dp_status status;
    t_out_item  result;

    // The sequencer decides what each item does: records the tilt, holds a pending gravity,
    // starts an insertion walk or issues a table read. It also owns the output valid flag.
    cpsi_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the point memory, the latest tilt, the pending gravity, the point
    // count, the walk pointer and the result register.
    cpsi_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (result)
    );

    assign o_out.data = result;

endmodule

### sv/cpsi_checker.sv
`include "calibration_point_sorted_insert_assert.svh"

module cpsi_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input cpsi_pkg::t_out_item  i_out_data
);
    import cpsi_pkg::*;

    // A stalled result beat keeps its contents.
    `CPSI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // One item at a time: right after an input beat the block is busy.
    `CPSI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // An item either inserts a point or reads an entry, never both.
    `CPSI_ASSERT_NOW(a_add_or_read, i_clk, i_rst_n, i_out_valid, !(i_out_data.point_added && i_out_data.entry_valid))

    // Fields that do not apply to the result are zero.
    `CPSI_ASSERT_NOW(a_unused_zero, i_clk, i_rst_n, i_out_valid, (i_out_data.point_added || (i_out_data.position == 4'd0)) && (i_out_data.entry_valid || ((i_out_data.entry_tilt == 16'd0) && (i_out_data.entry_gravity == 16'd0))))

endmodule

bind calibration_point_sorted_insert cpsi_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

### tb/calibration_table_checker.sv
`timescale 1ns / 100ps

module calibration_table_checker #(
    parameter int MAX_POINTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cpsi_in_if   i_in_mon,
    cpsi_out_if  i_out_mon,
    output int   o_errors,
    output int   o_waiting,
    output int   o_inserts,
    output int   o_full_rejects,
    output int   o_valid_reads,
    output int   o_point_total
);
    import cpsi_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the calibration table and the pairing state.
    logic [15:0] tilt_slots [MAX_POINTS];
    logic [15:0] gravity_slots [MAX_POINTS];
    int          point_total;
    logic [15:0] last_tilt;
    logic        have_tilt;
    logic [15:0] held_gravity;
    logic        have_held;

    t_out_item   expected_results [$];

    task automatic insert_sorted(input logic [15:0] tilt, input logic [15:0] gravity,
                                 output logic [3:0] slot);
        int s;
        int k;
        s = 0;
        while (s < point_total && tilt_slots[s] < tilt)
            s++;
        for (k = point_total; k > s; k--) begin
            tilt_slots[k]    = tilt_slots[k - 1];
            gravity_slots[k] = gravity_slots[k - 1];
        end
        tilt_slots[s]    = tilt;
        gravity_slots[s] = gravity;
        point_total++;
        slot = 4'(s);
    endtask

    task automatic predict_result(input t_in_item item, output t_out_item res);
        logic       room;
        logic [3:0] slot;
        room = (point_total < MAX_POINTS);
        res  = '0;
        case (item.func)
            FUNC_TILT: begin
                last_tilt = item.tilt;
                have_tilt = 1'b1;
                if (have_held && room) begin
                    insert_sorted(last_tilt, held_gravity, slot);
                    res.point_added = 1'b1;
                    res.position    = slot;
                    have_held       = 1'b0;
                    held_gravity    = '0;
                    o_inserts++;
                end else if (have_held) begin
                    o_full_rejects++;
                end
            end
            FUNC_GRAVITY: begin
                if (have_tilt && room) begin
                    insert_sorted(last_tilt, item.gravity, slot);
                    res.point_added = 1'b1;
                    res.position    = slot;
                    o_inserts++;
                end else begin
                    if (have_tilt)
                        o_full_rejects++;
                    held_gravity = item.gravity;
                    have_held    = 1'b1;
                end
            end
            FUNC_READ: begin
                if (int'(item.index) < point_total) begin
                    res.entry_valid   = 1'b1;
                    res.entry_tilt    = tilt_slots[item.index];
                    res.entry_gravity = gravity_slots[item.index];
                    o_valid_reads++;
                end
            end
            default: ;
        endcase
        res.point_count = 5'(point_total);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item got;
        t_out_item want;
        t_out_item predicted;
        if (!i_rst_n) begin
            point_total    = 0;
            last_tilt      = '0;
            have_tilt      = 1'b0;
            held_gravity   = '0;
            have_held      = 1'b0;
            o_errors       = 0;
            o_inserts      = 0;
            o_full_rejects = 0;
            o_valid_reads  = 0;
            expected_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_LIMIT)
                        $display("%0t: result beat with no expected result waiting", $realtime);
                end else begin
                    want = expected_results.pop_front();
                    if (got.point_added !== want.point_added ||
                        got.position !== want.position ||
                        got.point_count !== want.point_count ||
                        got.entry_valid !== want.entry_valid ||
                        got.entry_tilt !== want.entry_tilt ||
                        got.entry_gravity !== want.entry_gravity) begin
                        o_errors++;
                        if (o_errors <= REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected added=%0d pos=%0d count=%0d",
                                     $realtime, want.point_added, want.position,
                                     want.point_count);
                            $display("    valid=%0d tilt=%h gravity=%h, got added=%0d",
                                     want.entry_valid, want.entry_tilt, want.entry_gravity,
                                     got.point_added);
                            $display("    pos=%0d count=%0d valid=%0d tilt=%h gravity=%h",
                                     got.position, got.point_count, got.entry_valid,
                                     got.entry_tilt, got.entry_gravity);
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_result(i_in_mon.data, predicted);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
        o_waiting     = expected_results.size();
        o_point_total = point_total;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import cpsi_pkg::*;

    localparam int MAX_POINTS      = 16;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_ITEMS    = 1100;
    // The slowest result is an insertion into a nearly full table, so this drain window is
    // enough to catch any stray result beat at the end.
    localparam int DRAIN_CYCLES    = MAX_POINTS + 8;
    // Longest legal quiet stretch is the long receiver hold-off plus one insertion; the
    // watchdog allows many times that.
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int STALL_LIMIT     = 2000;

    // The fourth function code is not used by the block; it must be ignored.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    cpsi_in_if  in_ch ();
    cpsi_out_if out_ch ();

    int errors;
    int waiting;
    int inserts;
    int full_rejects;
    int valid_reads;
    int point_total;

    // Idle percentages of the two sides and the traffic phase, changed by the stimulus
    // process as the run moves on.
    int send_idle_pct;
    int take_idle_pct;
    int phase;
    int beats_sent;
    logic hold_done;

    calibration_point_sorted_insert #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    calibration_table_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) table_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_errors      (errors),
        .o_waiting     (waiting),
        .o_inserts     (inserts),
        .o_full_rejects(full_rejects),
        .o_valid_reads (valid_reads),
        .o_point_total (point_total)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Phase 0: sender idles lightly and receiver heavily. Phase 1 swaps the two.
    // Phase 2 runs with no idling at all on either side.
    task automatic set_phase(input int p);
        phase = p;
        case (p)
            0: begin
                send_idle_pct = 11;
                take_idle_pct = 48;
            end
            1: begin
                send_idle_pct = 48;
                take_idle_pct = 11;
            end
            default: begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
        endcase
    endtask

    function automatic t_in_item make_item(input logic [1:0] func, input logic [15:0] tilt,
                                           input logic [15:0] gravity,
                                           input logic [3:0] index);
        t_in_item item;
        item.func    = func;
        item.tilt    = tilt;
        item.gravity = gravity;
        item.index   = index;
        return item;
    endfunction

    // Reads dominate so that the table fills slowly and is read back at every fill level.
    // A share of the tilts comes from a tiny pool, so equal tilts are common.
    function automatic t_in_item random_item();
        t_in_item item;
        int       pick;
        item.tilt    = 16'($urandom);
        item.gravity = 16'($urandom);
        item.index   = 4'($urandom);
        pick         = $urandom_range(99);
        if (pick < 40)
            item.func = FUNC_READ;
        else if (pick < 65)
            item.func = FUNC_TILT;
        else if (pick < 93)
            item.func = FUNC_GRAVITY;
        else
            item.func = FUNC_UNUSED;
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0:       item.tilt = 16'h0000;
                1:       item.tilt = 16'hFFFF;
                default: item.tilt = 16'h2D00;
            endcase
        end
        return item;
    endfunction

    // Offers one beat on the input channel. It is entered and left at a falling edge, so
    // every input change lands half a cycle away from the sampling edge.
    task automatic send_beat(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.data  = item;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        beats_sent++;
    endtask

    // Receiver side. Once, at the start of the phase without idling, it holds ready low
    // for a long stretch while the sender keeps offering beats, so the output register
    // stays occupied and the block has to stall its input.
    initial begin
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (phase == 2 && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready = ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
        $display("Timeout: no beat moved for %0d cycles, %0d results still expected",
                 STALL_LIMIT, waiting);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int i;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        beats_sent  = 0;
        set_phase(0);
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reads of an empty table and an ignored code come first.
        send_beat(make_item(FUNC_READ, 16'h0000, 16'h0000, 4'd0));
        send_beat(make_item(FUNC_READ, 16'hFFFF, 16'hFFFF, 4'd15));
        send_beat(make_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 4'd15));
        // Gravity before any tilt is held, and a second one replaces the first.
        send_beat(make_item(FUNC_GRAVITY, 16'h0000, 16'd1234, 4'd0));
        send_beat(make_item(FUNC_GRAVITY, 16'h0000, 16'hFFFF, 4'd0));
        // The first tilt pairs with the held gravity.
        send_beat(make_item(FUNC_TILT, 16'h1000, 16'h0000, 4'd0));
        // A tilt with nothing held is only recorded; the gravity after it pairs at once.
        send_beat(make_item(FUNC_TILT, 16'hFFFF, 16'h0000, 4'd0));
        send_beat(make_item(FUNC_GRAVITY, 16'h0000, 16'h0000, 4'd0));
        send_beat(make_item(FUNC_TILT, 16'h0000, 16'hFFFF, 4'd0));
        send_beat(make_item(FUNC_GRAVITY, 16'hFFFF, 16'h8000, 4'd0));
        // Equal tilts: each new point goes in front of the stored ones with that tilt.
        send_beat(make_item(FUNC_TILT, 16'h1000, 16'h0000, 4'd0));
        send_beat(make_item(FUNC_GRAVITY, 16'h0000, 16'h5555, 4'd0));
        send_beat(make_item(FUNC_GRAVITY, 16'h0000, 16'hAAAA, 4'd0));
        // Read back the whole table, then just past its end and at the top index.
        for (i = 0; i < 6; i++)
            send_beat(make_item(FUNC_READ, 16'h0000, 16'h0000, 4'(i)));
        send_beat(make_item(FUNC_READ, 16'h0000, 16'h0000, 4'd15));

        // Random part, split evenly across the three traffic phases. The table fills up
        // early in it, so the full-table cases make up most of the later traffic.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (phase != (i * 3) / RANDOM_ITEMS)
                set_phase((i * 3) / RANDOM_ITEMS);
            send_beat(random_item());
        end
        in_ch.valid = 1'b0;

        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input beats: %0d points inserted (table at %0d of %0d),",
                 beats_sent, inserts, point_total, MAX_POINTS);
        $display("%0d points turned away by a full table, %0d valid reads, %0d failures.",
                 full_rejects, valid_reads, errors);
        if (errors == 0 && waiting == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
